// ===== rtl/cia_pkg.sv =====
// Shared types and constants for the complex integer ALU.
package cia_pkg;
    localparam int OPERAND_WIDTH = 16;
    localparam int OW  = OPERAND_WIDTH;
    localparam int PW  = 2 * OW;
    localparam int SW  = PW + 1;
    localparam int RW  = 33;
    localparam int QW  = SW;
    localparam int QCW = $clog2(QW + 1);

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    typedef logic signed [OW-1:0] t_opnd;
    typedef logic signed [RW-1:0] t_res;

    // State carried down the divider pipeline for one item
    typedef struct packed {
        logic          vld;
        logic [1:0]    kind;
        t_res          re;
        t_res          im;
        logic          dz;
        logic [QW-1:0] num_re;
        logic          neg_re;
        logic [QW-1:0] num_im;
        logic          neg_im;
        logic [SW-1:0] den;
        logic [QW-1:0] rem_re;
        logic [QW-1:0] rem_im;
        logic [QW-1:0] quo_re;
        logic [QW-1:0] quo_im;
    } t_stage;
endpackage

// ===== rtl/complex_integer_alu.sv =====
// Top level of the pipelined complex integer ALU.
//
//  channel  | handshake          | fields
//  ---------+--------------------+----------------------------------------
//  command  | start / busy       | i_kind, i_a_re, i_a_im, i_b_re, i_b_im
//  result   | o_valid strobe     | o_res_re, o_res_im, o_div_zero
//
// The pipeline has a product stage and a sum/divider-setup stage, one
// restoring-divider stage per quotient bit, and one output stage.
// All operations take the same path, so results leave in entry order.
// An item may enter every cycle; busy is always low.
// Reset clears only the valid bits of the pipeline.
module complex_integer_alu import cia_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_kind,
    input  t_opnd      i_a_re,
    input  t_opnd      i_a_im,
    input  t_opnd      i_b_re,
    input  t_opnd      i_b_im,
    output logic       o_valid,
    output t_res       o_res_re,
    output t_res       o_res_im,
    output logic       o_div_zero
);
    t_stage w_pipe [0:QW];
    logic   r_vld;
    t_res   r_re, r_im;
    logic   r_dz;
    t_stage w_last;
    logic [QW-1:0] w_qre, w_qim;

    assign busy = 1'b0;

    cia_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_kind  (i_kind),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_stage (w_pipe[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar g = 0; g < QW; g++) begin : g_div
        cia_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bit   (QCW'(QW - 1 - g)),
            .i_stage (w_pipe[g]),
            .o_stage (w_pipe[g+1])
        );
    end

    assign w_last = w_pipe[QW];
    assign w_qre  = w_last.neg_re ? -w_last.quo_re : w_last.quo_re;
    assign w_qim  = w_last.neg_im ? -w_last.quo_im : w_last.quo_im;

    // Select result and register outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_last.vld;
        end
        r_dz <= w_last.dz;
        if (w_last.kind == KIND_DIV) begin
            r_re <= w_last.dz ? '0 : RW'(w_qre);
            r_im <= w_last.dz ? '0 : RW'(w_qim);
        end else begin
            r_re <= w_last.re;
            r_im <= w_last.im;
        end
    end

    assign o_valid    = r_vld;
    assign o_res_re   = r_re;
    assign o_res_im   = r_im;
    assign o_div_zero = r_dz;
endmodule

// ===== rtl/cia_front.sv =====
// Front stages: operand products and sums, divider setup.
module cia_front import cia_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [1:0]    i_kind,
    input  t_opnd         i_a_re,
    input  t_opnd         i_a_im,
    input  t_opnd         i_b_re,
    input  t_opnd         i_b_im,
    output t_stage        o_stage
);
    logic          r_vld1;
    logic [1:0]    r_kind1;
    t_opnd         r_a_re, r_a_im, r_b_re, r_b_im;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    t_stage        r_st;
    t_stage        n_st;

    // Stage one: register operands and form products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
        r_kind1 <= i_kind;
        r_a_re  <= i_a_re;
        r_a_im  <= i_a_im;
        r_b_re  <= i_b_re;
        r_b_im  <= i_b_im;
        r_p_rr  <= i_a_re * i_b_re;
        r_p_ii  <= i_a_im * i_b_im;
        r_p_ri  <= i_a_re * i_b_im;
        r_p_ir  <= i_a_im * i_b_re;
        r_p_bb  <= i_b_re * i_b_re;
        r_p_cc  <= i_b_im * i_b_im;
    end

    // Stage two: combine products, sign-magnitude numerators
    logic signed [SW-1:0] w_sr, w_si, w_add_re, w_add_im, w_sub_re, w_sub_im;
    logic signed [SW-1:0] w_nre, w_nim;
    logic          [SW-1:0] w_den;
    logic signed [SW-1:0] w_ar, w_ai, w_br, w_bi;
    always_comb begin
        w_ar = SW'(r_a_re);
        w_ai = SW'(r_a_im);
        w_br = SW'(r_b_re);
        w_bi = SW'(r_b_im);
        w_sr = SW'(r_p_rr) - SW'(r_p_ii);
        w_si = SW'(r_p_ri) + SW'(r_p_ir);
        w_nre = SW'(r_p_rr) + SW'(r_p_ii);
        w_nim = SW'(r_p_ir) - SW'(r_p_ri);
        w_den = SW'(r_p_bb) + SW'(r_p_cc);
        w_add_re = w_ar + w_br;
        w_add_im = w_ai + w_bi;
        w_sub_re = w_br - w_ar;
        w_sub_im = w_bi - w_ai;
        n_st = '0;
        n_st.vld  = r_vld1;
        n_st.kind = r_kind1;
        case (r_kind1)
            KIND_ADD: begin
                n_st.re = RW'(w_add_re);
                n_st.im = RW'(w_add_im);
            end
            KIND_SUB: begin
                n_st.re = RW'(w_sub_re);
                n_st.im = RW'(w_sub_im);
            end
            default: begin
                n_st.re = '0;
                n_st.im = '0;
            end
        endcase
        n_st.neg_re = w_nre[SW-1];
        n_st.num_re = w_nre[SW-1] ? QW'(-w_nre) : QW'(w_nre);
        n_st.neg_im = w_nim[SW-1];
        n_st.num_im = w_nim[SW-1] ? QW'(-w_nim) : QW'(w_nim);
        n_st.den    = w_den;
        n_st.dz     = (r_kind1 == KIND_DIV) && (w_den == '0);
    end

    // Register the add, subtract or multiply result alongside the divider setup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else begin
            r_st.vld <= n_st.vld;
        end
        r_st.kind   <= n_st.kind;
        r_st.re     <= (n_st.kind == KIND_MUL) ? RW'(w_sr) : n_st.re;
        r_st.im     <= (n_st.kind == KIND_MUL) ? RW'(w_si) : n_st.im;
        r_st.dz     <= n_st.dz;
        r_st.num_re <= n_st.num_re;
        r_st.neg_re <= n_st.neg_re;
        r_st.num_im <= n_st.num_im;
        r_st.neg_im <= n_st.neg_im;
        r_st.den    <= n_st.den;
        r_st.rem_re <= '0;
        r_st.rem_im <= '0;
        r_st.quo_re <= '0;
        r_st.quo_im <= '0;
    end

    assign o_stage = r_st;
endmodule

// ===== rtl/cia_div_step.sv =====
// One pipelined restoring-division stage: one quotient bit per part.
module cia_div_step import cia_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [QCW-1:0] i_bit,
    input  t_stage        i_stage,
    output t_stage        o_stage
);
    t_stage r_st;
    t_stage n_st;
    logic [QW:0] w_tr, w_ti;

    // Shift in next numerator bit, subtract if it fits
    always_comb begin
        n_st = i_stage;
        w_tr = {i_stage.rem_re, i_stage.num_re[i_bit]};
        w_ti = {i_stage.rem_im, i_stage.num_im[i_bit]};
        if (w_tr >= (QW+1)'(i_stage.den)) begin
            n_st.rem_re = QW'(w_tr - (QW+1)'(i_stage.den));
            n_st.quo_re = {i_stage.quo_re[QW-2:0], 1'b1};
        end else begin
            n_st.rem_re = QW'(w_tr);
            n_st.quo_re = {i_stage.quo_re[QW-2:0], 1'b0};
        end
        if (w_ti >= (QW+1)'(i_stage.den)) begin
            n_st.rem_im = QW'(w_ti - (QW+1)'(i_stage.den));
            n_st.quo_im = {i_stage.quo_im[QW-2:0], 1'b1};
        end else begin
            n_st.rem_im = QW'(w_ti);
            n_st.quo_im = {i_stage.quo_im[QW-2:0], 1'b0};
        end
    end

    // Advance stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else begin
            r_st.vld <= n_st.vld;
        end
        r_st.kind   <= n_st.kind;
        r_st.re     <= n_st.re;
        r_st.im     <= n_st.im;
        r_st.dz     <= n_st.dz;
        r_st.num_re <= n_st.num_re;
        r_st.neg_re <= n_st.neg_re;
        r_st.num_im <= n_st.num_im;
        r_st.neg_im <= n_st.neg_im;
        r_st.den    <= n_st.den;
        r_st.rem_re <= n_st.rem_re;
        r_st.rem_im <= n_st.rem_im;
        r_st.quo_re <= n_st.quo_re;
        r_st.quo_im <= n_st.quo_im;
    end

    assign o_stage = r_st;
endmodule
